>>> rtl/mbsp_pkg.sv
// types, codes and constants shared by the midi byte stream parser
`timescale 1ns / 1ps

package mbsp_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned DATA_W = 7;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned POS_W  = 11;
  localparam int unsigned SKIP_W = 2;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned LEN_W  = 2;

  // parser modes
  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_TWO   = 3'd1,
    MODE_THREE = 3'd2,
    MODE_EXCL  = 3'd3,
    MODE_SKIP  = 3'd4
  } mode_e;

  // result kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_CHAN  = 2'd0,
    KIND_EXCL  = 2'd1,
    KIND_ABORT = 2'd2
  } kind_e;

  // status bytes with a meaning of their own
  localparam logic [BYTE_W-1:0] BYTE_SYSEX    = 8'hF0;
  localparam logic [BYTE_W-1:0] BYTE_MTC_QF   = 8'hF1;
  localparam logic [BYTE_W-1:0] BYTE_SONG_POS = 8'hF2;
  localparam logic [BYTE_W-1:0] BYTE_SONG_SEL = 8'hF3;
  localparam logic [BYTE_W-1:0] BYTE_TUNE_REQ = 8'hF6;
  localparam logic [BYTE_W-1:0] BYTE_EOX      = 8'hF7;
  localparam logic [BYTE_W-1:0] BYTE_CLOCK    = 8'hF8;
  localparam logic [BYTE_W-1:0] BYTE_START    = 8'hFA;
  localparam logic [BYTE_W-1:0] BYTE_CONTINUE = 8'hFB;
  localparam logic [BYTE_W-1:0] BYTE_STOP     = 8'hFC;
  localparam logic [BYTE_W-1:0] BYTE_SENSE    = 8'hFE;
  localparam logic [BYTE_W-1:0] BYTE_RESET    = 8'hFF;

  localparam logic [BYTE_W-1:0] RUNNING_RESET = 8'h80;

  localparam logic [POS_W-1:0] POS_ONE   = 11'd1;
  localparam logic [POS_W-1:0] POS_TWO   = 11'd2;
  localparam logic [POS_W-1:0] POS_THREE = 11'd3;

  localparam logic [SKIP_W-1:0] SKIP_ONE   = 2'd1;
  localparam logic [SKIP_W-1:0] SKIP_TWO   = 2'd2;
  localparam logic [SKIP_W-1:0] SKIP_THREE = 2'd3;

  localparam logic [LEN_W-1:0] LEN_NONE  = 2'd0;
  localparam logic [LEN_W-1:0] LEN_TWO   = 2'd2;
  localparam logic [LEN_W-1:0] LEN_THREE = 2'd3;

  function automatic logic is_realtime(input logic [BYTE_W-1:0] b);
    return (b == BYTE_CLOCK) || (b == BYTE_START) || (b == BYTE_CONTINUE) ||
           (b == BYTE_STOP) || (b == BYTE_SENSE) || (b == BYTE_RESET);
  endfunction

endpackage

>>> rtl/mbsp_if.sv
// valid/ready channels for raw midi bytes and parsed results
`timescale 1ns / 1ps

interface mbsp_byte_if;
  logic                         valid;
  logic                         ready;
  logic [mbsp_pkg::BYTE_W-1:0]  midi_byte;
  logic [mbsp_pkg::TIME_W-1:0]  time_stamp;

  modport source (output valid, output midi_byte, output time_stamp, input ready);
  modport sink   (input valid, input midi_byte, input time_stamp, output ready);
endinterface

interface mbsp_msg_if;
  logic                         valid;
  logic                         ready;
  logic [mbsp_pkg::KIND_W-1:0]  kind;
  logic [mbsp_pkg::BYTE_W-1:0]  status_byte;
  logic [mbsp_pkg::DATA_W-1:0]  first_data;
  logic [mbsp_pkg::DATA_W-1:0]  second_data;
  logic [mbsp_pkg::LEN_W-1:0]   msg_length;
  logic [mbsp_pkg::BYTE_W-1:0]  excl_byte;
  logic                         excl_last;
  logic [mbsp_pkg::TIME_W-1:0]  start_time;

  modport source (
    output valid, output kind, output status_byte, output first_data,
    output second_data, output msg_length, output excl_byte, output excl_last,
    output start_time, input ready
  );
  modport sink (
    input valid, input kind, input status_byte, input first_data,
    input second_data, input msg_length, input excl_byte, input excl_last,
    input start_time, output ready
  );
endinterface

>>> rtl/midi_byte_stream_parser.sv
// midi byte stream parser with running status, exclusive pass-through and skips
`timescale 1ns / 1ps

// usage
//   byte_i carries one raw midi byte and its arrival time per request; msg_o
//   carries at most one result per byte: a complete channel message, one
//   exclusive byte, or an exclusive abort on overflow
//   real-time bytes are swallowed anywhere and never produce a result
//   each byte is first captured in an input register, then decoded against
//   the parser state combinationally and written to the result register
//   a byte passes from the input register through the decode step into the
//   result register, which drives msg_o
//   throughput: one byte per cycle while msg_o is not stalled, set by the single
//   decode step between the input register and the result register
//   a stalled receiver holds the result register; the input register still
//   takes one more byte, then byte_i.ready drops until the result leaves
//   reset clears both registers' valid flags and returns the parser to idle
//   with running status 80
//   SYSEX_LIMIT is the exclusive position at which a message is aborted
module midi_byte_stream_parser #(
  parameter int unsigned SYSEX_LIMIT = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  mbsp_byte_if.sink        byte_i,
  mbsp_msg_if.source       msg_o
);

  localparam logic [mbsp_pkg::POS_W-1:0] LimitPos = mbsp_pkg::POS_W'(SYSEX_LIMIT);

  // input register
  logic                           in_vld_q;
  logic [mbsp_pkg::BYTE_W-1:0]    in_byte_q;
  logic [mbsp_pkg::TIME_W-1:0]    in_time_q;

  // parser state
  mbsp_pkg::mode_e                mode_q, mode_d;
  logic [mbsp_pkg::POS_W-1:0]     pos_q, pos_d;
  logic [mbsp_pkg::BYTE_W-1:0]    run_q, run_d;
  logic [mbsp_pkg::SKIP_W-1:0]    skip_q, skip_d;
  logic [mbsp_pkg::BYTE_W-1:0]    status_q, status_d;
  logic [mbsp_pkg::DATA_W-1:0]    first_q, first_d;
  logic [mbsp_pkg::TIME_W-1:0]    mtime_q, mtime_d;

  // result register
  logic                           out_vld_q;
  mbsp_pkg::kind_e                out_kind_q;
  logic [mbsp_pkg::BYTE_W-1:0]    out_status_q;
  logic [mbsp_pkg::DATA_W-1:0]    out_first_q;
  logic [mbsp_pkg::DATA_W-1:0]    out_second_q;
  logic [mbsp_pkg::LEN_W-1:0]     out_len_q;
  logic [mbsp_pkg::BYTE_W-1:0]    out_excl_q;
  logic                           out_last_q;
  logic [mbsp_pkg::TIME_W-1:0]    out_time_q;

  // decode results
  logic                           res_vld;
  mbsp_pkg::kind_e                res_kind;
  logic [mbsp_pkg::BYTE_W-1:0]    res_status;
  logic [mbsp_pkg::DATA_W-1:0]    res_first;
  logic [mbsp_pkg::DATA_W-1:0]    res_second;
  logic [mbsp_pkg::LEN_W-1:0]     res_len;
  logic [mbsp_pkg::BYTE_W-1:0]    res_excl;
  logic                           res_last;
  logic [mbsp_pkg::TIME_W-1:0]    res_time;

  logic                           adv;      // held byte is decoded this cycle
  logic                           work;     // decoded byte is not real-time
  logic                           in_rdy;
  logic [mbsp_pkg::POS_W-1:0]     pos_inc;

  // the held byte moves on once the result register is free or draining
  assign adv     = in_vld_q && (!out_vld_q || msg_o.ready);
  assign in_rdy  = !in_vld_q || adv;
  assign work    = adv && !mbsp_pkg::is_realtime(in_byte_q);
  assign pos_inc = pos_q + mbsp_pkg::POS_ONE;

  assign byte_i.ready = in_rdy;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_rdy) begin
      in_vld_q <= byte_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_rdy && byte_i.valid) begin
      in_byte_q <= byte_i.midi_byte;
      in_time_q <= byte_i.time_stamp;
    end
  end

  // next parser state
  always_comb begin
    mode_d   = mode_q;
    pos_d    = pos_q;
    run_d    = run_q;
    skip_d   = skip_q;
    status_d = status_q;
    first_d  = first_q;
    mtime_d  = mtime_q;
    if (work) begin
      unique case (mode_q)
        mbsp_pkg::MODE_TWO, mbsp_pkg::MODE_THREE: begin
          if (pos_q < mbsp_pkg::POS_TWO) begin
            first_d = in_byte_q[mbsp_pkg::DATA_W-1:0];
            pos_d   = mbsp_pkg::POS_TWO;
            if (mode_q == mbsp_pkg::MODE_TWO) begin
              mode_d = mbsp_pkg::MODE_IDLE;
            end
          end else begin
            mode_d = mbsp_pkg::MODE_IDLE;
            pos_d  = mbsp_pkg::POS_THREE;
          end
        end
        mbsp_pkg::MODE_EXCL: begin
          pos_d = pos_inc;
          if (in_byte_q == mbsp_pkg::BYTE_EOX || pos_inc >= LimitPos) begin
            mode_d = mbsp_pkg::MODE_IDLE;
          end
        end
        mbsp_pkg::MODE_SKIP: begin
          pos_d = pos_inc;
          if (pos_inc >= mbsp_pkg::POS_W'(skip_q)) begin
            mode_d = mbsp_pkg::MODE_IDLE;
          end
        end
        default: begin
          // idle: decode a fresh status or a running-status data byte
          unique case (in_byte_q) inside
            [8'h00:8'h7F]: begin
              status_d = run_q;
              first_d  = in_byte_q[mbsp_pkg::DATA_W-1:0];
              mtime_d  = in_time_q;
              pos_d    = mbsp_pkg::POS_TWO;
              mode_d   = mbsp_pkg::MODE_THREE;
            end
            [8'h80:8'hBF], [8'hE0:8'hEF]: begin
              run_d    = in_byte_q;
              status_d = in_byte_q;
              mtime_d  = in_time_q;
              pos_d    = mbsp_pkg::POS_ONE;
              mode_d   = mbsp_pkg::MODE_THREE;
            end
            [8'hC0:8'hDF]: begin
              status_d = in_byte_q;
              mtime_d  = in_time_q;
              pos_d    = mbsp_pkg::POS_ONE;
              mode_d   = mbsp_pkg::MODE_TWO;
            end
            mbsp_pkg::BYTE_SYSEX: begin
              status_d = in_byte_q;
              mtime_d  = in_time_q;
              pos_d    = mbsp_pkg::POS_ONE;
              mode_d   = mbsp_pkg::MODE_EXCL;
            end
            mbsp_pkg::BYTE_SONG_POS: begin
              status_d = in_byte_q;
              mtime_d  = in_time_q;
              pos_d    = mbsp_pkg::POS_ONE;
              skip_d   = mbsp_pkg::SKIP_THREE;
              mode_d   = mbsp_pkg::MODE_SKIP;
            end
            mbsp_pkg::BYTE_MTC_QF, mbsp_pkg::BYTE_SONG_SEL: begin
              status_d = in_byte_q;
              mtime_d  = in_time_q;
              pos_d    = mbsp_pkg::POS_ONE;
              skip_d   = mbsp_pkg::SKIP_TWO;
              mode_d   = mbsp_pkg::MODE_SKIP;
            end
            mbsp_pkg::BYTE_TUNE_REQ: begin
              status_d = in_byte_q;
              mtime_d  = in_time_q;
              pos_d    = mbsp_pkg::POS_ONE;
              skip_d   = mbsp_pkg::SKIP_ONE;
              mode_d   = mbsp_pkg::MODE_SKIP;
            end
            default: begin
              // undefined system status: no state change
            end
          endcase
        end
      endcase
    end
  end

  // result of the decoded byte
  always_comb begin
    res_vld    = 1'b0;
    res_kind   = mbsp_pkg::KIND_CHAN;
    res_status = '0;
    res_first  = '0;
    res_second = '0;
    res_len    = mbsp_pkg::LEN_NONE;
    res_excl   = '0;
    res_last   = 1'b0;
    res_time   = mtime_q;
    if (work) begin
      unique case (mode_q)
        mbsp_pkg::MODE_TWO, mbsp_pkg::MODE_THREE: begin
          res_status = status_q;
          if (pos_q < mbsp_pkg::POS_TWO) begin
            res_vld   = (mode_q == mbsp_pkg::MODE_TWO);
            res_first = in_byte_q[mbsp_pkg::DATA_W-1:0];
            res_len   = mbsp_pkg::LEN_TWO;
          end else begin
            res_vld    = 1'b1;
            res_first  = first_q;
            res_second = in_byte_q[mbsp_pkg::DATA_W-1:0];
            res_len    = mbsp_pkg::LEN_THREE;
          end
        end
        mbsp_pkg::MODE_EXCL: begin
          res_vld  = 1'b1;
          res_excl = in_byte_q;
          if (in_byte_q == mbsp_pkg::BYTE_EOX) begin
            res_kind = mbsp_pkg::KIND_EXCL;
            res_last = 1'b1;
          end else if (pos_inc >= LimitPos) begin
            res_kind = mbsp_pkg::KIND_ABORT;
          end else begin
            res_kind = mbsp_pkg::KIND_EXCL;
          end
        end
        mbsp_pkg::MODE_SKIP: begin
          res_vld = 1'b0;
        end
        default: begin
          if (in_byte_q == mbsp_pkg::BYTE_SYSEX) begin
            res_vld  = 1'b1;
            res_kind = mbsp_pkg::KIND_EXCL;
            res_excl = in_byte_q;
            res_time = in_time_q;
          end
        end
      endcase
    end
  end

  // parser state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= mbsp_pkg::MODE_IDLE;
      pos_q    <= '0;
      run_q    <= mbsp_pkg::RUNNING_RESET;
      skip_q   <= '0;
      status_q <= '0;
      first_q  <= '0;
      mtime_q  <= '0;
    end else begin
      mode_q   <= mode_d;
      pos_q    <= pos_d;
      run_q    <= run_d;
      skip_q   <= skip_d;
      status_q <= status_d;
      first_q  <= first_d;
      mtime_q  <= mtime_d;
    end
  end

  // result register: loads on a result, clears when taken with nothing new
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= res_vld;
    end else if (msg_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && res_vld) begin
      out_kind_q   <= res_kind;
      out_status_q <= res_status;
      out_first_q  <= res_first;
      out_second_q <= res_second;
      out_len_q    <= res_len;
      out_excl_q   <= res_excl;
      out_last_q   <= res_last;
      out_time_q   <= res_time;
    end
  end

  assign msg_o.valid       = out_vld_q;
  assign msg_o.kind        = out_kind_q;
  assign msg_o.status_byte = out_status_q;
  assign msg_o.first_data  = out_first_q;
  assign msg_o.second_data = out_second_q;
  assign msg_o.msg_length  = out_len_q;
  assign msg_o.excl_byte   = out_excl_q;
  assign msg_o.excl_last   = out_last_q;
  assign msg_o.start_time  = out_time_q;

`ifndef ASSERT_OFF
  // a real-time byte never leaves a result behind
  a_realtime_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && mbsp_pkg::is_realtime(in_byte_q)) |=> !out_vld_q)
    else $error("real-time byte produced a result");

  // exclusive position stays below the abort limit
  a_excl_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == mbsp_pkg::MODE_EXCL) |-> (pos_q >= mbsp_pkg::POS_ONE && pos_q < LimitPos))
    else $error("exclusive position out of range");

  // skip mode never runs past its target
  a_skip_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == mbsp_pkg::MODE_SKIP) |-> (pos_q <= mbsp_pkg::POS_W'(skip_q)))
    else $error("skip position past target");

  // a two-byte message waits for its single data byte
  a_two_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == mbsp_pkg::MODE_TWO) |-> (pos_q == mbsp_pkg::POS_ONE))
    else $error("two-byte message at wrong position");

  // an empty result register never stalls the input side
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_vld_q |-> in_rdy)
    else $error("input stalled with empty result register");
`endif

endmodule
